// ----- sv/dtt_pkg.sv -----
`timescale 1ns / 1ps
// Shared package of the detection tracking table.
// Holds codes, register indices, reset values and the controller/datapath interface types.
package dtt_pkg;

    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_COORD_BITS  = 12;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int FRAME_W   = 10;
    localparam int KIND_W    = 4;

    localparam logic [FRAME_W-1:0] FRAME_MAX = 10'd1023;

    localparam logic [KIND_W-1:0] KIND_GOLD_LO = 4'd4;
    localparam logic [KIND_W-1:0] KIND_GOLD_HI = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LARGE   = 4'd7;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_SMALL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_LARGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_SMALL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_LARGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP        = 3'd7;

    // Reset values: 50*50, 75*75, 60, 120, 85*85, 50*50, 80*80, 1000.
    localparam logic [CFG_W-1:0]   RST_MATCH_SMALL = 24'd2500;
    localparam logic [CFG_W-1:0]   RST_MATCH_LARGE = 24'd5625;
    localparam logic [FRAME_W-1:0] RST_MEM_SMALL   = 10'd60;
    localparam logic [FRAME_W-1:0] RST_MEM_LARGE   = 10'd120;
    localparam logic [CFG_W-1:0]   RST_REPLACE     = 24'd7225;
    localparam logic [CFG_W-1:0]   RST_QUERY       = 24'd2500;
    localparam logic [CFG_W-1:0]   RST_CORRECT     = 24'd6400;
    localparam logic [FRAME_W-1:0] RST_WRAP        = 10'd1000;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_FRESET  = 3'd1,
        ACT_TRACK   = 3'd2,
        ACT_QUERY   = 3'd3,
        ACT_CORRECT = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        MODE_EVICT   = 2'd0,
        MODE_MATCH   = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_CORRECT = 2'd3
    } t_scan_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVICT,
        S_PREP,
        S_MATCH,
        S_WRITE,
        S_QUERY,
        S_CORRECT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       start;
        t_scan_mode mode;
        logic       issue;
        logic       clr;
        logic       write_back;
        logic       capture;
    } t_ctl_cmd;

    typedef struct packed {
        logic hit;
        logic empty;
    } t_dp_stat;

    function automatic logic is_gold(input logic [KIND_W-1:0] k);
        return (k >= KIND_GOLD_LO) && (k <= KIND_GOLD_HI);
    endfunction

endpackage

// ----- sv/dtt_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the detection tracking table: registers, entry memory, distance pipeline.
// Depends on dtt_pkg; driven by dtt_ctrl through t_ctl_cmd.
module dtt_datapath #(
    parameter int TABLE_DEPTH = dtt_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = dtt_pkg::DEF_COORD_BITS,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [2:0]                    i_action,
    input  logic [COORD_BITS-1:0]         i_x_pos,
    input  logic [COORD_BITS-1:0]         i_y_pos,
    input  logic [dtt_pkg::KIND_W-1:0]    i_coin_kind,
    input  logic                          i_count_it,
    input  dtt_pkg::t_ctl_cmd             i_cmd,
    input  logic [AW-1:0]                 i_rd_addr,
    output dtt_pkg::t_dp_stat             o_stat,
    output logic                          o_already_counted,
    output logic [dtt_pkg::KIND_W-1:0]    o_found_kind,
    output logic                          o_dropped,
    output logic [dtt_pkg::FRAME_W-1:0]   o_frame_now
);

    localparam int FW = dtt_pkg::FRAME_W;
    localparam int KW = dtt_pkg::KIND_W;
    localparam int EW = 2 * COORD_BITS + KW + FW + 1;
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int CW = (DW > dtt_pkg::CFG_W) ? DW : dtt_pkg::CFG_W;

    // Configuration registers.
    logic [dtt_pkg::CFG_W-1:0] r_match_small, r_match_large, r_replace, r_query, r_correct;
    logic [FW-1:0]             r_mem_small, r_mem_large, r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_small <= dtt_pkg::RST_MATCH_SMALL;
            r_match_large <= dtt_pkg::RST_MATCH_LARGE;
            r_mem_small   <= dtt_pkg::RST_MEM_SMALL;
            r_mem_large   <= dtt_pkg::RST_MEM_LARGE;
            r_replace     <= dtt_pkg::RST_REPLACE;
            r_query       <= dtt_pkg::RST_QUERY;
            r_correct     <= dtt_pkg::RST_CORRECT;
            r_wrap        <= dtt_pkg::RST_WRAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtt_pkg::REG_MATCH_SMALL: r_match_small <= i_cfg_data;
                dtt_pkg::REG_MATCH_LARGE: r_match_large <= i_cfg_data;
                dtt_pkg::REG_MEM_SMALL:   r_mem_small   <= i_cfg_data[FW-1:0];
                dtt_pkg::REG_MEM_LARGE:   r_mem_large   <= i_cfg_data[FW-1:0];
                dtt_pkg::REG_REPLACE:     r_replace     <= i_cfg_data;
                dtt_pkg::REG_QUERY:       r_query       <= i_cfg_data;
                dtt_pkg::REG_CORRECT:     r_correct     <= i_cfg_data;
                dtt_pkg::REG_WRAP:        r_wrap        <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // Latched item.
    logic [2:0]            r_act;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [KW-1:0]         r_kind;
    logic                  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
            r_kind <= i_coin_kind;
            r_cnt  <= i_count_it;
        end
    end

    // Frame counter, updated as the item is taken.
    logic [FW-1:0] r_frame;
    logic [FW:0]   frame_inc;

    assign frame_inc = {1'b0, r_frame} + {{FW{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_cmd.load) begin
            if (i_action == dtt_pkg::ACT_TICK) begin
                if (frame_inc > {1'b0, r_wrap} || frame_inc > {1'b0, dtt_pkg::FRAME_MAX}) begin
                    r_frame <= '0;
                end else begin
                    r_frame <= frame_inc[FW-1:0];
                end
            end else if (i_action == dtt_pkg::ACT_FRESET) begin
                r_frame <= '0;
            end
        end
    end

    // Scan outcome registers.
    logic          r_hit, r_free_vld, r_best_vld, r_hit_counted;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [KW-1:0] r_hit_kind, r_best_kind;
    logic [CW-1:0] r_best_d;

    // Entry memory with per-entry valid bits; an invalid entry reads as all zero.
    logic [EW-1:0]          mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [EW-1:0]          r_rd_data;
    logic                   r_rd_vld;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_rd_addr];
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end else if (i_cmd.clr && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Stage one: unpack and square the coordinate differences.
    logic                  r_p1, r_p2;
    logic [AW-1:0]         r_p1_idx, r_p2_idx;
    logic [COORD_BITS-1:0] e_x, e_y, dx, dy;
    logic [KW-1:0]         e_kind;
    logic [FW-1:0]         e_stamp;
    logic                  e_counted;

    assign e_x       = r_rd_vld ? r_rd_data[EW-1 -: COORD_BITS] : '0;
    assign e_y       = r_rd_vld ? r_rd_data[EW-1-COORD_BITS -: COORD_BITS] : '0;
    assign e_kind    = r_rd_vld ? r_rd_data[FW+KW:FW+1] : '0;
    assign e_stamp   = r_rd_vld ? r_rd_data[FW:1] : '0;
    assign e_counted = r_rd_vld ? r_rd_data[0] : 1'b0;
    assign dx = (e_x >= r_x) ? e_x - r_x : r_x - e_x;
    assign dy = (e_y >= r_y) ? e_y - r_y : r_y - e_y;

    logic [2*COORD_BITS-1:0] r_sqx, r_sqy;
    logic                    r_e_live, r_e_counted;
    logic [KW-1:0]           r_e_kind;
    logic [FW-1:0]           r_e_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= i_cmd.issue;
            r_p2 <= r_p1;
        end
        r_p1_idx    <= i_rd_addr;
        r_p2_idx    <= r_p1_idx;
        r_sqx       <= dx * dx;
        r_sqy       <= dy * dy;
        r_e_live    <= (e_x != '0) || (e_y != '0);
        r_e_kind    <= e_kind;
        r_e_stamp   <= e_stamp;
        r_e_counted <= e_counted;
    end

    // Stage two: sum, compare and decide.
    logic [DW-1:0] dsum;
    logic [CW-1:0] d;
    logic          big_kind, e_gold, stamp_ok;
    logic [CW-1:0] rad;
    logic [FW-1:0] win, age;

    assign dsum     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign d        = CW'(dsum);
    assign big_kind = r_kind >= dtt_pkg::KIND_LARGE;
    assign e_gold   = dtt_pkg::is_gold(r_e_kind);
    assign rad      = big_kind ? CW'(r_match_large) : CW'(r_match_small);
    assign win      = big_kind ? r_mem_large : r_mem_small;
    assign age      = r_frame - r_e_stamp;
    assign stamp_ok = (r_e_stamp > r_frame) || (age < win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (r_p2 && !r_hit) begin
            unique case (i_cmd.mode)
                dtt_pkg::MODE_EVICT: begin
                    if (r_e_live && e_gold && d <= CW'(r_replace)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_p2_idx;
                    end
                end
                dtt_pkg::MODE_MATCH: begin
                    if (!r_e_live) begin
                        if (!r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_p2_idx;
                        end
                    end else if (d <= rad && stamp_ok) begin
                        r_hit         <= 1'b1;
                        r_hit_idx     <= r_p2_idx;
                        r_hit_kind    <= r_e_kind;
                        r_hit_counted <= r_e_counted;
                    end
                end
                dtt_pkg::MODE_QUERY: begin
                    if (r_e_live && d <= CW'(r_query) && (!r_best_vld || d < r_best_d)) begin
                        r_best_vld  <= 1'b1;
                        r_best_d    <= d;
                        r_best_kind <= r_e_kind;
                    end
                end
                dtt_pkg::MODE_CORRECT: begin
                    if (r_e_live && e_gold && d <= CW'(r_correct)) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_p2_idx;
                        r_hit_kind <= r_e_kind;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.hit   = r_hit;
    assign o_stat.empty = !r_p1 && !r_p2;

    // Write-back of a matched or inserted entry.
    logic [KW-1:0] upd_kind;

    assign upd_kind = (big_kind && dtt_pkg::is_gold(r_hit_kind)) ? r_kind : r_hit_kind;
    assign wr_en    = i_cmd.write_back && (r_hit || r_free_vld);
    assign wr_addr  = r_hit ? r_hit_idx : r_free_idx;
    assign wr_data  = r_hit ? {r_x, r_y, upd_kind, r_frame, r_hit_counted | r_cnt}
                            : {r_x, r_y, r_kind, r_frame, r_cnt};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_already_counted <= 1'b0;
            o_found_kind      <= '0;
            o_dropped         <= 1'b0;
            o_frame_now       <= r_frame;
            unique case (r_act)
                dtt_pkg::ACT_TRACK: begin
                    o_already_counted <= r_hit && r_hit_counted;
                    o_dropped         <= !r_hit && !r_free_vld;
                end
                dtt_pkg::ACT_QUERY:   o_found_kind <= r_best_vld ? r_best_kind : '0;
                dtt_pkg::ACT_CORRECT: o_found_kind <= r_hit ? r_hit_kind : '0;
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/dtt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the detection tracking table: sequences scans, write-back and the result.
// Depends on dtt_pkg; commands dtt_datapath.
module dtt_ctrl #(
    parameter int TABLE_DEPTH = dtt_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  logic [2:0]        i_action,
    input  logic [3:0]        i_coin_kind,
    input  dtt_pkg::t_dp_stat i_stat,
    output dtt_pkg::t_ctl_cmd o_cmd,
    output logic [AW-1:0]     o_rd_addr
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    dtt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_out_vld, n_out_vld;
    logic             scanning, all_issued, scan_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtt_pkg::S_IDLE;
            r_addr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_out_vld <= n_out_vld;
        end
    end

    assign scanning   = (r_state == dtt_pkg::S_EVICT) || (r_state == dtt_pkg::S_MATCH) ||
                        (r_state == dtt_pkg::S_QUERY) || (r_state == dtt_pkg::S_CORRECT);
    assign all_issued = r_addr == CNT_W'(TABLE_DEPTH);
    assign scan_done  = (all_issued || i_stat.hit) && i_stat.empty;
    assign o_rd_addr  = r_addr[AW-1:0];
    assign o_valid    = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_out_vld = r_out_vld && !i_ready;
        o_ready   = 1'b0;
        o_cmd     = '0;
        o_cmd.mode = dtt_pkg::MODE_MATCH;
        unique case (r_state)
            dtt_pkg::S_EVICT:   o_cmd.mode = dtt_pkg::MODE_EVICT;
            dtt_pkg::S_QUERY:   o_cmd.mode = dtt_pkg::MODE_QUERY;
            dtt_pkg::S_CORRECT: o_cmd.mode = dtt_pkg::MODE_CORRECT;
            default: ;
        endcase
        if (scanning && !all_issued && !i_stat.hit) begin
            o_cmd.issue = 1'b1;
            n_addr      = r_addr + CNT_W'(1);
        end
        unique case (r_state)
            dtt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.start = 1'b1;
                    n_addr      = '0;
                    unique case (i_action)
                        dtt_pkg::ACT_TRACK:
                            n_state = (i_coin_kind >= dtt_pkg::KIND_LARGE) ?
                                      dtt_pkg::S_EVICT : dtt_pkg::S_MATCH;
                        dtt_pkg::ACT_QUERY:   n_state = dtt_pkg::S_QUERY;
                        dtt_pkg::ACT_CORRECT: n_state = dtt_pkg::S_CORRECT;
                        default:              n_state = dtt_pkg::S_DONE;
                    endcase
                end
            end
            dtt_pkg::S_EVICT: begin
                if (scan_done) begin
                    o_cmd.clr = 1'b1;
                    n_state   = dtt_pkg::S_PREP;
                end
            end
            dtt_pkg::S_PREP: begin
                o_cmd.start = 1'b1;
                n_addr      = '0;
                n_state     = dtt_pkg::S_MATCH;
            end
            dtt_pkg::S_MATCH: begin
                if (scan_done) begin
                    n_state = dtt_pkg::S_WRITE;
                end
            end
            dtt_pkg::S_WRITE: begin
                o_cmd.write_back = 1'b1;
                n_state          = dtt_pkg::S_DONE;
            end
            dtt_pkg::S_QUERY: begin
                if (scan_done) begin
                    n_state = dtt_pkg::S_DONE;
                end
            end
            dtt_pkg::S_CORRECT: begin
                if (scan_done) begin
                    o_cmd.clr = 1'b1;
                    n_state   = dtt_pkg::S_DONE;
                end
            end
            dtt_pkg::S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    o_cmd.capture = 1'b1;
                    n_out_vld     = 1'b1;
                    n_state       = dtt_pkg::S_IDLE;
                end
            end
            default: n_state = dtt_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- sv/detection_tracking_table.sv -----
`timescale 1ns / 1ps
// Sequencing: tick, frame reset and unknown actions go straight to the result; query and
// correct scan the table once; track scans it once, or twice for classes 7+, then writes back.
// Throughput: one transaction at a time, set by the single read port of the entry memory,
// which is scanned one entry per cycle. Reset (synchronous, active low) clears all entries
// through per-entry valid bits at once, zeroes the frame counter and restores the registers.
// Depends on dtt_pkg, dtt_ctrl and dtt_datapath.
module detection_tracking_table #(
    parameter int TABLE_DEPTH = dtt_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = dtt_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_action,
    input  logic [COORD_BITS-1:0]         i_x_pos,
    input  logic [COORD_BITS-1:0]         i_y_pos,
    input  logic [dtt_pkg::KIND_W-1:0]    i_coin_kind,
    input  logic                          i_count_it,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_already_counted,
    output logic [dtt_pkg::KIND_W-1:0]    o_found_kind,
    output logic                          o_dropped,
    output logic [dtt_pkg::FRAME_W-1:0]   o_frame_now
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // The controller walks the table one entry per cycle; the datapath reads the entry,
    // squares the coordinate differences, then compares against the active radius.
    dtt_pkg::t_ctl_cmd cmd;
    dtt_pkg::t_dp_stat stat;
    logic [AW-1:0]     rd_addr;

    dtt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_action    (i_action),
        .i_coin_kind (i_coin_kind),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    // The result register sits in the datapath and is loaded only once the previous
    // transaction on the output side has been taken.
    dtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS),
        .AW          (AW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_x_pos           (i_x_pos),
        .i_y_pos           (i_y_pos),
        .i_coin_kind       (i_coin_kind),
        .i_count_it        (i_count_it),
        .i_cmd             (cmd),
        .i_rd_addr         (rd_addr),
        .o_stat            (stat),
        .o_already_counted (o_already_counted),
        .o_found_kind      (o_found_kind),
        .o_dropped         (o_dropped),
        .o_frame_now       (o_frame_now)
    );

endmodule
